[hdl/infix_expression_evaluator_macros.svh]
// ----------------------------------------------------------------------------
// infix_expression_evaluator_macros.svh
// Concurrent assertion shorthands; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define IEE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define IEE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/iee_pkg.sv]
// ----------------------------------------------------------------------------
// iee_pkg
// Shared codes, types and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_ADD    = 3'd1;
    localparam opcode_t OP_SUB    = 3'd2;
    localparam opcode_t OP_MUL    = 3'd3;
    localparam opcode_t OP_DIV    = 3'd4;
    localparam opcode_t OP_LPAREN = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_DIVZERO   = 2'd1;
    localparam status_t ST_MALFORMED = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] ASC_PLUS   = 8'h2B;
    localparam logic [7:0] ASC_MINUS  = 8'h2D;
    localparam logic [7:0] ASC_STAR   = 8'h2A;
    localparam logic [7:0] ASC_SLASH  = 8'h2F;
    localparam logic [7:0] ASC_LPAREN = 8'h28;
    localparam logic [7:0] ASC_RPAREN = 8'h29;
    localparam logic [7:0] ASC_ZERO   = 8'h30;
    localparam logic [7:0] ASC_NINE   = 8'h39;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic    start;
        opcode_t op;
    } alu_req_t;

    function automatic logic is_high_prec(opcode_t op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

[hdl/iee_ram.sv]
// ----------------------------------------------------------------------------
// iee_ram
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/iee_alu.sv]
// ----------------------------------------------------------------------------
// iee_alu
// Shared arithmetic unit: add/sub done the cycle after the request, shift-add
// multiply and restoring divide at one bit per cycle. Wrapping, truncating toward zero.
// ----------------------------------------------------------------------------
module iee_alu #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  iee_pkg::alu_req_t req,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    import iee_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg,  div_next;
    logic             neg_reg,  neg_next;
    logic [CW-1:0]    cnt_reg,  cnt_next;
    logic [WIDTH-1:0] acc_reg,  acc_next;
    logic [WIDTH-1:0] x_reg,    x_next;
    logic [WIDTH-1:0] y_reg,    y_next;
    logic [WIDTH-1:0] rem_reg,  rem_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;

        rem_sh = {rem_reg, x_reg[WIDTH-1]};
        diff   = rem_sh - {1'b0, y_reg};

        if (req.start)
        begin
            case (req.op)
                OP_SUB:
                begin
                    acc_next  = a - b;
                    done_next = 1'b1;
                end
                OP_MUL:
                begin
                    acc_next  = '0;
                    x_next    = a;
                    y_next    = b;
                    div_next  = 1'b0;
                    cnt_next  = CW'(WIDTH);
                    busy_next = 1'b1;
                end
                OP_DIV:
                begin
                    rem_next  = '0;
                    x_next    = a[WIDTH-1] ? -a : a;
                    y_next    = b[WIDTH-1] ? -b : b;
                    neg_next  = a[WIDTH-1] ^ b[WIDTH-1];
                    div_next  = 1'b1;
                    cnt_next  = CW'(WIDTH);
                    busy_next = 1'b1;
                end
                default:
                begin
                    acc_next  = a + b;
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                // sign fix of the quotient in its own cycle
                if (div_reg)
                begin
                    acc_next = neg_reg ? -x_reg : x_reg;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                if (div_reg)
                begin
                    if (!diff[WIDTH])
                    begin
                        rem_next = diff[WIDTH-1:0];
                        x_next   = {x_reg[WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh[WIDTH-1:0];
                        x_next   = {x_reg[WIDTH-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[WIDTH-2:0], 1'b0};
                    y_next = {1'b0, y_reg[WIDTH-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

[hdl/infix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// A digit or '(' is taken in S_IDLE and finished in S_END. An operator or ')'
// passes S_TOP, then S_TOPCHK if the operator stack is not empty, and for each
// operator it pops S_RDB, S_RDA, S_GO and S_WAIT until the shared ALU is done.
// The word marked last adds the final drain, S_CHK and S_OUT before the result.
// Throughput: one word at a time, set by the sequencer and the shared ALU.
// Reset: asynchronous, clears counters, error and handshake state; stacks hold.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import iee_pkg::*;
    `include "infix_expression_evaluator_macros.svh"

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_END    = 4'd1;
    localparam logic [3:0] S_TOP    = 4'd2;
    localparam logic [3:0] S_TOPCHK = 4'd3;
    localparam logic [3:0] S_RDB    = 4'd4;
    localparam logic [3:0] S_RDA    = 4'd5;
    localparam logic [3:0] S_GO     = 4'd6;
    localparam logic [3:0] S_WAIT   = 4'd7;
    localparam logic [3:0] S_CHK    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]             state_reg,  state_next;
    logic [7:0]             sym_reg,    sym_next;
    logic                   last_reg,   last_next;
    logic                   fin_reg,    fin_next;
    opcode_t                newop_reg,  newop_next;
    opcode_t                top_reg,    top_next;
    logic [VALUE_WIDTH-1:0] b_reg,      b_next;
    logic [CNTW-1:0]        vcnt_reg,   vcnt_next;
    logic [CNTW-1:0]        opcnt_reg,  opcnt_next;
    logic [CNTW-1:0]        binops_reg, binops_next;
    status_t                err_reg,    err_next;
    logic                   mvalid_reg, mvalid_next;
    logic [31:0]            mdata_reg,  mdata_next;
    status_t                muser_reg,  muser_next;

    logic                   val_we;
    logic [AW-1:0]          val_waddr;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic [AW-1:0]          val_raddr;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic                   op_we;
    logic [AW-1:0]          op_waddr;
    opcode_t                op_wdata;
    opcode_t                op_rdata;

    alu_req_t               alu_req;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;

    logic [CNTW-1:0]        vm1, vm2, opm1;
    logic                   eq_bin, eq_bin1;
    logic                   in_digit, in_op, in_lp, in_rp;
    opcode_t                in_opcode;
    logic [7:0]             digit;
    logic                   close_mode;
    logic                   vfull, ofull;
    status_t                fin_status;

    iee_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_value_stack (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    iee_ram #(
        .WIDTH ($bits(opcode_t)),
        .DEPTH (STACK_DEPTH)
    ) u_op_stack (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_wdata),
        .raddr (opm1[AW-1:0]),
        .rdata (op_rdata)
    );

    iee_alu #(
        .WIDTH (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (val_rdata),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        vm1  = vcnt_reg - CNTW'(1);
        vm2  = vcnt_reg - CNTW'(2);
        opm1 = opcnt_reg - CNTW'(1);

        // operand expected when values match binary operators
        eq_bin  = ((CNTW+1)'(vcnt_reg) == (CNTW+1)'(binops_reg));
        eq_bin1 = ((CNTW+1)'(vcnt_reg) == ((CNTW+1)'(binops_reg) + (CNTW+1)'(1)));
        vfull   = (vcnt_reg == CNTW'(STACK_DEPTH));
        ofull   = (opcnt_reg == CNTW'(STACK_DEPTH));

        in_digit = s_axis_tdata inside {[ASC_ZERO:ASC_NINE]};
        in_op    = s_axis_tdata inside {ASC_PLUS, ASC_MINUS, ASC_STAR, ASC_SLASH};
        in_lp    = (s_axis_tdata == ASC_LPAREN);
        in_rp    = (s_axis_tdata == ASC_RPAREN);
        digit    = s_axis_tdata - ASC_ZERO;
        case (s_axis_tdata)
            ASC_MINUS: in_opcode = OP_SUB;
            ASC_STAR:  in_opcode = OP_MUL;
            ASC_SLASH: in_opcode = OP_DIV;
            default:   in_opcode = OP_ADD;
        endcase

        close_mode = (sym_reg == ASC_RPAREN);

        if (err_reg != ST_OK)
        begin
            fin_status = err_reg;
        end
        else if (vcnt_reg != CNTW'(1))
        begin
            fin_status = ST_MALFORMED;
        end
        else
        begin
            fin_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        fin_next    = fin_reg;
        newop_next  = newop_reg;
        top_next    = top_reg;
        b_next      = b_reg;
        vcnt_next   = vcnt_reg;
        opcnt_next  = opcnt_reg;
        binops_next = binops_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;

        val_we    = 1'b0;
        val_waddr = vcnt_reg[AW-1:0];
        val_wdata = VALUE_WIDTH'(digit[3:0]);
        val_raddr = '0;
        op_we     = 1'b0;
        op_waddr  = opcnt_reg[AW-1:0];
        op_wdata  = newop_reg;
        alu_req   = '0;

        s_axis_tready = (state_reg == S_IDLE);

        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sym_next   = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    newop_next = in_opcode;
                    state_next = S_END;
                    if (err_reg == ST_OK)
                    begin
                        if (in_digit)
                        begin
                            if (!eq_bin)
                            begin
                                err_next = ST_MALFORMED;
                            end
                            else if (vfull)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                val_we    = 1'b1;
                                vcnt_next = vcnt_reg + CNTW'(1);
                            end
                        end
                        else if (in_lp)
                        begin
                            if (!eq_bin)
                            begin
                                err_next = ST_MALFORMED;
                            end
                            else if (ofull)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                op_we      = 1'b1;
                                op_wdata   = OP_LPAREN;
                                opcnt_next = opcnt_reg + CNTW'(1);
                            end
                        end
                        else if (in_rp || in_op)
                        begin
                            if (!eq_bin1)
                            begin
                                err_next = ST_MALFORMED;
                            end
                            else
                            begin
                                state_next = S_TOP;
                            end
                        end
                        else
                        begin
                            err_next = ST_MALFORMED;
                        end
                    end
                end
            end

            S_END:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (err_reg != ST_OK)
                begin
                    state_next = S_OUT;
                end
                else if (!eq_bin1)
                begin
                    err_next   = ST_MALFORMED;
                    state_next = S_OUT;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = S_TOP;
                end
            end

            S_TOP:
            begin
                if (opcnt_reg == '0)
                begin
                    if (fin_reg)
                    begin
                        state_next = S_CHK;
                    end
                    else if (close_mode)
                    begin
                        err_next   = ST_MALFORMED;
                        state_next = S_END;
                    end
                    else
                    begin
                        op_we       = 1'b1;
                        opcnt_next  = opcnt_reg + CNTW'(1);
                        binops_next = binops_reg + CNTW'(1);
                        state_next  = S_END;
                    end
                end
                else
                begin
                    state_next = S_TOPCHK;
                end
            end

            S_TOPCHK:
            begin
                top_next = op_rdata;
                if (fin_reg)
                begin
                    if (op_rdata == OP_LPAREN)
                    begin
                        err_next   = ST_MALFORMED;
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_RDB;
                    end
                end
                else if (close_mode)
                begin
                    if (op_rdata == OP_LPAREN)
                    begin
                        opcnt_next = opm1;
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_RDB;
                    end
                end
                else if ((op_rdata == OP_LPAREN) ||
                         (!is_high_prec(op_rdata) && is_high_prec(newop_reg)))
                begin
                    // '(' is never popped by precedence
                    if (ofull)
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        op_we       = 1'b1;
                        opcnt_next  = opcnt_reg + CNTW'(1);
                        binops_next = binops_reg + CNTW'(1);
                    end
                    state_next = S_END;
                end
                else
                begin
                    state_next = S_RDB;
                end
            end

            S_RDB:
            begin
                if (vcnt_reg < CNTW'(2))
                begin
                    err_next   = ST_MALFORMED;
                    state_next = S_END;
                end
                else
                begin
                    val_raddr  = vm1[AW-1:0];
                    state_next = S_RDA;
                end
            end

            S_RDA:
            begin
                b_next     = val_rdata;
                val_raddr  = vm2[AW-1:0];
                state_next = S_GO;
            end

            S_GO:
            begin
                val_raddr = vm2[AW-1:0];
                if ((top_reg == OP_DIV) && (b_reg == '0))
                begin
                    err_next   = ST_DIVZERO;
                    state_next = S_END;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = top_reg;
                    state_next    = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (alu_done)
                begin
                    val_we      = 1'b1;
                    val_waddr   = vm2[AW-1:0];
                    val_wdata   = alu_result;
                    vcnt_next   = vm1;
                    opcnt_next  = opm1;
                    binops_next = binops_reg - CNTW'(1);
                    state_next  = S_TOP;
                end
            end

            S_CHK:
            begin
                // read data at stack bottom is valid next cycle
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = fin_status;
                    mdata_next  = (fin_status == ST_OK) ? 32'(val_rdata) : '0;
                    vcnt_next   = '0;
                    opcnt_next  = '0;
                    binops_next = '0;
                    err_next    = ST_OK;
                    fin_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            vcnt_reg   <= '0;
            opcnt_reg  <= '0;
            binops_reg <= '0;
            err_reg    <= ST_OK;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            vcnt_reg   <= vcnt_next;
            opcnt_reg  <= opcnt_next;
            binops_reg <= binops_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        newop_reg <= newop_next;
        top_reg   <= top_next;
        b_reg     <= b_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    `IEE_ASSERT_ALWAYS(a_binops_le_ops, binops_reg <= opcnt_reg,
        "binary op count exceeds op count")
    `IEE_ASSERT_ALWAYS(a_counts_in_range,
        (vcnt_reg <= CNTW'(STACK_DEPTH)) && (opcnt_reg <= CNTW'(STACK_DEPTH)),
        "stack count out of range")
    `IEE_ASSERT_IMPLY(a_err_value_zero, m_axis_tvalid && (m_axis_tuser != ST_OK),
        m_axis_tdata == '0, "nonzero value with error status")
    `IEE_ASSERT_IMPLY(a_alu_done_in_wait, alu_done, state_reg == S_WAIT,
        "ALU result outside wait state")
    `IEE_ASSERT_NEXT(a_accept_to_end, s_axis_tvalid && s_axis_tready,
        (state_reg == S_END) || (state_reg == S_TOP), "bad state after word accept")

endmodule
